// ===== hw/rtl/slri_pkg.sv =====
// shared types, opcodes and status codes of the sorted list block
package slri_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 64;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned POS_W          = 6;
  localparam int unsigned ST_W           = 2;
  localparam int unsigned CNT_OUT_W      = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
    key_t key;
  } slri_ctl_t;

endpackage

// ===== hw/rtl/slri_in_if.sv =====
// input channel of the sorted list block
interface slri_in_if import slri_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  key_t             key;
  logic [POS_W-1:0] position;

  modport source (output valid, output opcode, output key, output position, input ready);
  modport sink   (input valid, input opcode, input key, input position, output ready);
endinterface

// ===== hw/rtl/slri_out_if.sv =====
// result channel of the sorted list block
interface slri_out_if import slri_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic [CNT_OUT_W-1:0] entry_count;
  key_t                 head_key;
  key_t                 read_key;

  modport source (output valid, output status, output entry_count, output head_key,
                  output read_key, input ready);
  modport sink   (input valid, input status, input entry_count, input head_key,
                  input read_key, output ready);
endinterface

// ===== hw/rtl/slri_cell.sv =====
// one list cell: holds a key, compares it and shifts with its neighbors
module slri_cell import slri_pkg::*; (
  input  logic      clk_i,
  input  slri_ctl_t ctl_i,
  input  logic      occ_i,
  input  key_t      left_key_i,
  input  logic      left_gt_i,
  input  key_t      right_key_i,
  output key_t      key_o,
  output logic      gt_o,
  output logic      eq_o
);

  key_t key_q, key_d;

  assign gt_o  = occ_i && (key_q > ctl_i.key);
  assign eq_o  = occ_i && (key_q == ctl_i.key);
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    if (ctl_i.ins && !gt_o) begin
      key_d = left_gt_i ? ctl_i.key : left_key_i;
    end else if (ctl_i.rem && !gt_o) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// ===== hw/rtl/sorted_list_insert_remove.sv =====
// top level of the sorted list block: a row of key cells with insert, remove and read
//
// Keeps up to LIST_DEPTH signed Q16.16 keys in descending order, one key per cell.
// Input channel in_i carries opcode, key and position; result channel out_o carries
// status, entry_count, head_key and read_key, one result transaction per input.
// An insert drops into place and a remove closes the gap in the update step, with every
// cell comparing its key against the broadcast key and shifting with its neighbor.
// A read selects the cell at position through a two-level registered OR tree.
// The result passes the cell update in S_EXEC and the tree reduction into the output
// register in S_RED before it is valid. One item is in work at a time, so the block
// takes no new item before the last has left S_RED, but it takes one while a finished
// result still waits in the output register.
// When the receiver stalls, the finished result stays in the output register and the
// next item halts in its last step until that register is free.
// Reset empties the list (count zero) and clears the handshake state; the keys in
// the cells are not cleared, and positions at or beyond the count are never read.
module sorted_list_insert_remove import slri_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slri_in_if.sink    in_i,
  slri_out_if.source out_o
);

  localparam int unsigned CW   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned EW   = (CW > POS_W + 1) ? CW : POS_W + 1;
  localparam int unsigned RD   = (LIST_DEPTH < (1 << POS_W)) ? LIST_DEPTH : (1 << POS_W);
  localparam int unsigned NGRP = (RD + 7) / 8;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RED} state_e;

  state_e           state_q;
  logic [OP_W-1:0]  op_q;
  key_t             key_q;
  logic [POS_W-1:0] pos_q;
  logic [CW-1:0]    count_q;
  logic [ST_W-1:0]  status_q;
  key_t             grp_q [NGRP];

  logic                 out_valid_q;
  logic [ST_W-1:0]      out_status_q;
  logic [CNT_OUT_W-1:0] out_count_q;
  key_t                 out_head_q;
  key_t                 out_read_q;

  slri_ctl_t ctl;
  key_t      cell_key [LIST_DEPTH];
  logic      cell_gt  [LIST_DEPTH];
  logic      cell_eq  [LIST_DEPTH];
  logic      cell_occ [LIST_DEPTH];
  logic      found, is_full, rd_ok, out_free;
  key_t      grp_d [NGRP];
  key_t      tree_key;

  // boundary cell is the first one not greater than the key; equal keys start there
  always_comb begin
    found = 1'b0;
    for (int unsigned i = 0; i < LIST_DEPTH; i++) begin
      if (cell_eq[i] && ((i == 0) || cell_gt[(i == 0) ? 0 : i - 1])) begin
        found = 1'b1;
      end
    end
  end

  assign is_full  = (count_q == CW'(LIST_DEPTH));
  assign rd_ok    = (EW'(pos_q) < EW'(count_q));
  assign ctl      = '{ins: (state_q == S_EXEC) && (op_q == OP_INSERT) && !is_full,
                      rem: (state_q == S_EXEC) && (op_q == OP_REMOVE) && found,
                      key: key_q};
  assign out_free = !out_valid_q || out_o.ready;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    assign cell_occ[i] = (CW'(i) < count_q);
    slri_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (cell_occ[i]),
      .left_key_i  ((i == 0) ? key_q : cell_key[(i == 0) ? 0 : i - 1]),
      .left_gt_i   ((i == 0) ? 1'b1 : cell_gt[(i == 0) ? 0 : i - 1]),
      .right_key_i ((i == LIST_DEPTH - 1) ? cell_key[i] :
                    cell_key[(i == LIST_DEPTH - 1) ? i : i + 1]),
      .key_o       (cell_key[i]),
      .gt_o        (cell_gt[i]),
      .eq_o        (cell_eq[i])
    );
  end

  // first tree level: one OR over eight selected cells per group
  always_comb begin
    for (int unsigned g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int unsigned j = 0; j < 8; j++) begin
        if ((g * 8 + j < RD) && rd_ok && (pos_q == POS_W'(g * 8 + j))) begin
          grp_d[g] = grp_d[g] | cell_key[(g * 8 + j < RD) ? g * 8 + j : 0];
        end
      end
    end
  end

  always_comb begin
    tree_key = '0;
    for (int unsigned g = 0; g < NGRP; g++) begin
      tree_key = tree_key | grp_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      op_q         <= '0;
      key_q        <= '0;
      pos_q        <= '0;
      status_q     <= ST_DONE;
      out_status_q <= ST_DONE;
      out_count_q  <= '0;
      out_head_q   <= '0;
      out_read_q   <= '0;
      for (int unsigned g = 0; g < NGRP; g++) begin
        grp_q[g] <= '0;
      end
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_RED)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= in_i.opcode;
            key_q   <= in_i.key;
            pos_q   <= in_i.position;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_q)
            OP_INSERT: begin
              if (is_full) begin
                status_q <= ST_FULL;
              end else begin
                status_q <= ST_DONE;
                count_q  <= count_q + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (found) begin
                status_q <= ST_DONE;
                count_q  <= count_q - CW'(1);
              end else begin
                status_q <= ST_NOT_FOUND;
              end
            end
            OP_READ: begin
              status_q <= rd_ok ? ST_DONE : ST_BAD_POS;
            end
            default: begin
              status_q <= ST_DONE;
            end
          endcase
          for (int unsigned g = 0; g < NGRP; g++) begin
            grp_q[g] <= (op_q == OP_READ) ? grp_d[g] : '0;
          end
          state_q <= S_RED;
        end
        S_RED: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_count_q  <= CNT_OUT_W'(count_q);
            out_head_q   <= (count_q != '0) ? cell_key[0] : '0;
            out_read_q   <= tree_key;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.head_key    = out_head_q;
  assign out_o.read_key    = out_read_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && (op_q == OP_INSERT) && is_full
    |=> (status_q == ST_FULL) && $stable(count_q))
    else $error("insert into full list not dropped");

  a_count_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EXEC) |=> $stable(count_q))
    else $error("entry count changed outside update step");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> (state_q == S_EXEC))
    else $error("accepted transaction not executed");

endmodule

// ===== tb/slri_result_check.sv =====
// result predictor and comparator for the sorted list block, watching both channels
module slri_result_check import slri_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  slri_in_if          in_mon,
  slri_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct {
    logic [ST_W-1:0]      status;
    logic [CNT_OUT_W-1:0] entry_count;
    key_t                 head_key;
    key_t                 read_key;
  } list_result_t;

  key_t         shadow_keys [LIST_DEPTH_DEF];
  int unsigned  shadow_len = 0;
  list_result_t awaited_results [$];
  int unsigned  fail_total = 0;
  int unsigned  awaited_total = 0;

  assign fail_count_o = fail_total;
  assign pending_o    = awaited_total;

  function automatic list_result_t apply_to_shadow_list(logic [OP_W-1:0] op, key_t k,
                                                        logic [POS_W-1:0] pos);
    list_result_t r;
    int unsigned  at;
    int unsigned  i;
    bit           hit;
    r.status   = ST_DONE;
    r.read_key = '0;
    hit        = 1'b0;
    at         = 0;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= LIST_DEPTH_DEF) begin
          r.status = ST_FULL;
        end else begin
          while (at < shadow_len && shadow_keys[at] > k) at++;
          for (i = shadow_len; i > at; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[at] = k;
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        while (at < shadow_len && !hit) begin
          if (shadow_keys[at] == k) begin
            for (i = at; i + 1 < shadow_len; i++) shadow_keys[i] = shadow_keys[i+1];
            shadow_len--;
            hit = 1'b1;
          end else begin
            at++;
          end
        end
        if (!hit) r.status = ST_NOT_FOUND;
      end
      OP_READ: begin
        if (pos < shadow_len) r.read_key = shadow_keys[pos];
        else r.status = ST_BAD_POS;
      end
      default: ;
    endcase
    r.entry_count = CNT_OUT_W'(shadow_len);
    r.head_key    = (shadow_len > 0) ? shadow_keys[0] : '0;
    return r;
  endfunction

  task automatic compare_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    list_result_t want;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready)
        awaited_results.push_back(apply_to_shadow_list(in_mon.opcode, in_mon.key,
                                                       in_mon.position));
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with nothing pending");
          fail_total++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", KEY_W'(want.status), KEY_W'(out_mon.status));
          compare_field("entry_count", KEY_W'(want.entry_count), KEY_W'(out_mon.entry_count));
          compare_field("head_key", want.head_key, out_mon.head_key);
          compare_field("read_key", want.read_key, out_mon.read_key);
        end
      end
    end
    awaited_total <= awaited_results.size();
  end

endmodule

// ===== tb/sorted_list_insert_remove_tb.sv =====
// stimulus and verdict for the sorted list block
module sorted_list_insert_remove_tb;
  import slri_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
  localparam int unsigned     ITEM_TARGET    = 1900;
  localparam int unsigned     QUIET_FROM     = 1750;
  localparam int unsigned     LONG_HOLD      = 400;
  localparam int unsigned     WATCHDOG_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni;

  slri_in_if  in_ch ();
  slri_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  bit          quiet_run = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_issued = 1'b0;
  int unsigned idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  sorted_list_insert_remove uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  slri_result_check result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic key_t pool_key(int unsigned n);
    case (n)
      0:       return key_t'(32'h7fff_ffff);
      1:       return key_t'(32'h8000_0000);
      2:       return key_t'(32'h0000_0000);
      3:       return key_t'(32'hffff_ffff);
      4:       return key_t'(32'h0001_0000);
      5:       return key_t'(32'hffff_0000);
      6:       return key_t'(32'h0000_8000);
      default: return key_t'(32'h7fff_0000);
    endcase
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(0, 2))
      0:       return pool_key($urandom_range(0, 7));
      1:       return key_t'((int'($urandom_range(0, 6)) - 3) * 65536);
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic offer(input logic [OP_W-1:0] op, input key_t k, input logic [POS_W-1:0] pos);
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.key      <= k;
    in_ch.position <= pos;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (!quiet_run && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_INSERT;
    in_ch.key      <= '0;
    in_ch.position <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver side
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet_run && $urandom_range(0, 99) < 20) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned ins_pct;
    int unsigned j;
    int unsigned pick;
    logic [OP_W-1:0] op;
    sent = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // empty list, ignored opcode, extremes, duplicates, reads in and out of range
    offer(OP_READ,   '0, 6'd0);
    offer(OP_REMOVE, key_t'(32'h0000_0005), 6'd0);
    offer(OP_UNUSED, key_t'(32'h1234_5678), 6'd9);
    offer(OP_INSERT, pool_key(2), 6'd0);
    offer(OP_INSERT, pool_key(0), 6'd63);
    offer(OP_INSERT, pool_key(1), 6'd0);
    offer(OP_INSERT, pool_key(0), 6'd0);
    offer(OP_INSERT, pool_key(4), 6'd0);
    offer(OP_INSERT, pool_key(5), 6'd0);
    offer(OP_INSERT, pool_key(2), 6'd0);
    offer(OP_READ,   '0, 6'd0);
    offer(OP_READ,   '0, 6'd1);
    offer(OP_READ,   '0, 6'd6);
    offer(OP_READ,   '0, 6'd7);
    offer(OP_READ,   '0, 6'd63);
    offer(OP_REMOVE, pool_key(1), 6'd0);
    offer(OP_REMOVE, pool_key(0), 6'd0);
    offer(OP_REMOVE, key_t'(32'h0000_3039), 6'd0);
    offer(OP_REMOVE, pool_key(2), 6'd0);
    offer(OP_UNUSED, key_t'($urandom), 6'($urandom));
    offer(OP_READ,   '0, 6'd0);

    while (sent < ITEM_TARGET) begin
      phase_len = $urandom_range(40, 200);
      case ($urandom_range(0, 2))
        0:       ins_pct = 85;
        1:       ins_pct = 50;
        default: ins_pct = 15;
      endcase
      if (!hold_issued) ins_pct = 85;
      for (j = 0; j < phase_len && sent < ITEM_TARGET; j++) begin
        if (!hold_issued && sent == 60) begin
          hold_req    = 1'b1;
          hold_issued = 1'b1;
        end
        if (sent >= QUIET_FROM) quiet_run = 1'b1;
        if ($urandom_range(0, 99) < 3) begin
          op = OP_UNUSED;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < ins_pct) op = OP_INSERT;
          else if (pick[0]) op = OP_REMOVE;
          else op = OP_READ;
          sent++;
        end
        offer(op, pick_key(), 6'($urandom_range(0, 63)));
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (12) @(posedge clk_i);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
